FILE: rtl/dff_pkg.sv
// Shared types and constants for the distance frame formatter.
`timescale 1ns / 1ps

package dff_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_TRANSMIT_ENABLE = 2'd0;
  localparam logic [1:0] REG_DEVICE_NUMBER   = 2'd1;
  localparam logic [1:0] REG_ABORT_LIMIT     = 2'd2;

  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned DIST_W     = 16;
  localparam int unsigned MAX_DIGITS = 5;

  // Result kinds
  localparam logic KIND_BYTE  = 1'b0;
  localparam logic KIND_ABORT = 1'b1;

  // ASCII
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  // floor(x / 10) == (x * 52429) >> 19 for every 16-bit x
  localparam logic [16:0] RECIP10       = 17'd52429;
  localparam int unsigned RECIP10_SHIFT = 19;

  typedef struct packed {
    logic        link_busy;
    logic [15:0] distance_cm;
  } dff_in_t;

  typedef struct packed {
    logic       out_kind;
    logic [7:0] frame_byte;
    logic       last;
  } dff_out_t;

endpackage

FILE: rtl/dff_div10.sv
// Shared divide-by-ten unit: reciprocal multiply, remainder by multiply-back and subtract.
`timescale 1ns / 1ps

module dff_div10 (
  input  logic [15:0] value,
  output logic [15:0] quot,
  output logic [3:0]  rem
);
  import dff_pkg::*;

  logic [32:0] product;
  logic [12:0] q;
  logic [15:0] q_times10;
  logic [15:0] diff;

  assign product   = {17'd0, value} * {16'd0, RECIP10};
  assign q         = product[RECIP10_SHIFT +: 13];
  assign q_times10 = {q, 3'b000} + {2'b00, q, 1'b0};
  assign diff      = value - q_times10;
  assign quot      = {3'b000, q};
  assign rem       = diff[3:0];

endmodule

FILE: rtl/distance_frame_formatter.sv
// Top level of the distance frame formatter: tick decode, digit sequencer, byte output.
`timescale 1ns / 1ps

// One input transfer is one broadcast tick. With transmit_enable low the tick
// is absorbed and nothing comes out. A busy tick bumps the busy counter; when
// it reaches abort_limit the counter clears and a single abort result
// (out_kind=1, frame_byte=0, last=1) is sent. A ready tick clears the counter
// and produces the frame "*D<tens><units>:<distance>\r\n", 8 to 12 byte
// transfers, last set on the LF. Timing: in_ready is high only in the idle
// state. A ready tick is accepted, then the decimal digits of the distance
// (1 to 5) and the two device digits are worked out, all on one shared
// divide-by-ten unit, then the frame goes out at one byte per cycle while
// the sink keeps out_ready high. A busy or disabled tick leaves the block
// idle; an abort passes through the abort state. A result register sits on
// the output, so the last byte may still wait while the next tick is taken.
module distance_frame_formatter (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  dff_pkg::dff_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output dff_pkg::dff_out_t out_data,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data
);
  import dff_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DIV   = 6'b000010,  // distance digits, least significant first
    S_DEV   = 6'b000100,  // device units digit
    S_DEV2  = 6'b001000,  // device tens digit
    S_EMIT  = 6'b010000,  // frame bytes
    S_ABORT = 6'b100000
  } state_t;

  // Configuration
  logic       transmit_enable;
  logic [6:0] device_number;
  logic [7:0] abort_limit;

  // Sequencer state
  state_t     state, state_next;
  logic [7:0] busy_count, busy_count_next;
  logic [15:0] work, work_next;
  logic [3:0] digits [MAX_DIGITS];
  logic [2:0] nd, nd_next;          // digits collected
  logic [2:0] rem_d, rem_d_next;    // digits still to send
  logic [2:0] pos, pos_next;        // frame section pointer
  logic [3:0] dev_units, dev_tens;

  // Output register
  logic       out_valid_next;
  dff_out_t   out_next;
  logic       push;
  logic       can_push;

  // Shared divider
  logic [15:0] div_quot;
  logic [3:0]  div_rem;

  dff_div10 u_div10 (
    .value (work),
    .quot  (div_quot),
    .rem   (div_rem)
  );

  logic       accept;
  logic [7:0] count_inc;
  logic [2:0] digit_idx;
  logic [7:0] frame_byte;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign count_inc = busy_count + 8'd1;
  assign can_push  = !out_valid || out_ready;
  assign digit_idx = rem_d - 3'd1;

  // Config writes; index 3 is ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      transmit_enable <= 1'b0;
      device_number   <= 7'd0;
      abort_limit     <= 8'd3;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TRANSMIT_ENABLE: transmit_enable <= cfg_data[0];
        REG_DEVICE_NUMBER:   device_number   <= cfg_data[6:0];
        REG_ABORT_LIMIT:     abort_limit     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Byte for the current frame position: header, digits, CR, LF
  always_comb begin
    case (pos)
      3'd0:    frame_byte = CH_STAR;
      3'd1:    frame_byte = CH_D;
      3'd2:    frame_byte = CH_ZERO + {4'd0, dev_tens};
      3'd3:    frame_byte = CH_ZERO + {4'd0, dev_units};
      3'd4:    frame_byte = CH_COLON;
      3'd5:    frame_byte = CH_ZERO + {4'd0, digits[digit_idx]};
      3'd6:    frame_byte = CH_CR;
      default: frame_byte = CH_LF;
    endcase
  end

  always_comb begin
    state_next      = state;
    busy_count_next = busy_count;
    work_next       = work;
    nd_next         = nd;
    rem_d_next      = rem_d;
    pos_next        = pos;
    push            = 1'b0;
    out_next        = out_data;

    unique case (state)
      S_IDLE: begin
        if (accept && transmit_enable) begin
          if (in_data.link_busy) begin
            if (count_inc >= abort_limit) begin
              busy_count_next = 8'd0;
              state_next      = S_ABORT;
            end else begin
              busy_count_next = count_inc;
            end
          end else begin
            busy_count_next = 8'd0;
            work_next       = in_data.distance_cm;
            nd_next         = 3'd0;
            state_next      = S_DIV;
          end
        end
      end
      S_DIV: begin
        nd_next   = nd + 3'd1;
        work_next = div_quot;
        if (div_quot == 16'd0) begin
          work_next  = {9'd0, device_number};
          state_next = S_DEV;
        end
      end
      S_DEV: begin
        work_next  = div_quot;
        state_next = S_DEV2;
      end
      S_DEV2: begin
        pos_next   = 3'd0;
        rem_d_next = nd;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (can_push) begin
          push     = 1'b1;
          out_next = '{out_kind: KIND_BYTE, frame_byte: frame_byte,
                       last: (pos == 3'd7)};
          if (pos == 3'd5) begin
            rem_d_next = rem_d - 3'd1;
            if (rem_d == 3'd1) pos_next = 3'd6;
          end else if (pos == 3'd7) begin
            state_next = S_IDLE;
          end else begin
            pos_next = pos + 3'd1;
          end
        end
      end
      S_ABORT: begin
        if (can_push) begin
          push       = 1'b1;
          out_next   = '{out_kind: KIND_ABORT, frame_byte: 8'd0, last: 1'b1};
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase

    out_valid_next = push || (out_valid && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      busy_count <= 8'd0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      busy_count <= busy_count_next;
      out_valid  <= out_valid_next;
    end
  end

  // Datapath registers, no reset needed
  always_ff @(posedge clk) begin
    work  <= work_next;
    nd    <= nd_next;
    rem_d <= rem_d_next;
    pos   <= pos_next;
    if (push) out_data <= out_next;
    if (state == S_DIV) digits[nd] <= div_rem;
    if (state == S_DEV) dev_units <= div_rem;
    if (state == S_DEV2) dev_tens <= div_rem;
  end

  // An abort result is a lone, final, zero byte
  a_abort_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.out_kind == KIND_ABORT) |->
      out_data.last && (out_data.frame_byte == 8'd0))
    else $error("abort result malformed");

  // A frame always closes on LF
  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.out_kind == KIND_BYTE) && out_data.last |->
      out_data.frame_byte == CH_LF)
    else $error("frame does not end in LF");

  // A ready tick on an enabled block clears the busy counter
  a_ready_clears: assert property (@(posedge clk) disable iff (rst)
    accept && transmit_enable && !in_data.link_busy |=> busy_count == 8'd0)
    else $error("busy counter not cleared on ready tick");

  // Digit collection never runs past five digits
  a_digit_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (nd < 3'd5))
    else $error("too many distance digits");

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for distance_frame_formatter: ticks in, frame bytes and abort requests out.
`timescale 1ns / 1ps

module tb_top;
  import dff_pkg::*;

  localparam int unsigned SETTLE_CYCLES  = 40;    // covers a busy tick still in flight
  localparam int unsigned HOLD_CYCLES    = 400;   // long sink hold-off, fills the block
  localparam int unsigned HOLD_AFTER     = 200;   // results seen before the hold-off starts
  localparam int unsigned WATCHDOG_LIMIT = 3000;  // cycles with no transfer on either side

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_ready;
  dff_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  dff_out_t out_data;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_TRANSMIT_ENABLE;
  logic [7:0] cfg_data = '0;

  always #10 clk = ~clk;

  distance_frame_formatter i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Formatter model: register copies, busy counter, and the results it predicts
  // ---------------------------------------------------------------------------
  logic       tx_en     = 1'b0;
  logic [6:0] dev_num   = 7'd0;
  logic [7:0] abort_lim = 8'd3;
  logic [7:0] busy_cnt  = 8'd0;

  dff_in_t  tick_q[$];       // ticks waiting for the driver
  dff_out_t link_out_q[$];   // predicted frame bytes / abort requests, oldest first
  int       err_cnt = 0;
  int       results_seen = 0;

  // Works out what one accepted tick produces and queues it.
  function automatic void frame_tick(dff_in_t t);
    logic [7:0]  frame[$];
    logic [7:0]  digs[$];
    int unsigned d;
    dff_out_t    r;
    if (!tx_en) return;                 // disabled: nothing out, counter kept
    if (t.link_busy) begin
      busy_cnt = busy_cnt + 8'd1;
      if (busy_cnt >= abort_lim) begin  // >= so a lowered limit aborts at once
        busy_cnt = 8'd0;
        r.out_kind   = KIND_ABORT;
        r.frame_byte = 8'h00;
        r.last       = 1'b1;
        link_out_q.push_back(r);
      end
      return;
    end
    busy_cnt = 8'd0;
    frame.push_back(CH_STAR);
    frame.push_back(CH_D);
    frame.push_back(CH_ZERO + 8'((dev_num / 10) % 10));  // 127 -> "27"
    frame.push_back(CH_ZERO + 8'(dev_num % 10));
    frame.push_back(CH_COLON);
    d = t.distance_cm;
    do begin
      digs.push_front(CH_ZERO + 8'(d % 10));
      d = d / 10;
    end while (d != 0);
    foreach (digs[i]) frame.push_back(digs[i]);
    frame.push_back(CH_CR);
    frame.push_back(CH_LF);
    foreach (frame[i]) begin
      r.out_kind   = KIND_BYTE;
      r.frame_byte = frame[i];
      r.last       = (i == frame.size() - 1);
      link_out_q.push_back(r);
    end
  endfunction

  function automatic dff_in_t make_tick(logic busy, logic [15:0] distance);
    dff_in_t t;
    t.link_busy   = busy;
    t.distance_cm = distance;
    return t;
  endfunction

  // Mostly short numbers so every digit count shows up, plus full-range values.
  function automatic logic [15:0] pick_distance();
    case ($urandom_range(0, 5))
      0:       return 16'($urandom_range(0, 9));
      1:       return 16'($urandom_range(10, 99));
      2:       return 16'($urandom_range(100, 999));
      3:       return 16'($urandom_range(1000, 9999));
      4:       return 16'($urandom_range(10000, 65535));
      default: return 16'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: bursts of random length, random gaps; prediction on each transfer
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (in_valid && in_ready) frame_tick(in_data);
      // slot is free unless a tick is still waiting for in_ready
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (tick_q.size() > 0) begin
          in_valid <= 1'b1;
          in_data  <= tick_q.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left   <= ($urandom_range(0, 4) < 2) ? 0 : $urandom_range(1, 15);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: sink stall pattern, one long hold-off, field-by-field compare
  // ---------------------------------------------------------------------------
  int   hold_left = 0;
  logic hold_done = 1'b0;
  int   stall_mode = 0;
  int   mode_left  = 0;

  always @(posedge clk) begin
    dff_out_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (link_out_q.size() == 0) begin
          $error("unexpected result kind=%0d byte=%h last=%0d",
                 out_data.out_kind, out_data.frame_byte, out_data.last);
          err_cnt++;
        end else begin
          want = link_out_q.pop_front();
          if (out_data.out_kind !== want.out_kind) begin
            $error("out_kind: expected %0d, got %0d", want.out_kind, out_data.out_kind);
            err_cnt++;
          end
          if (out_data.frame_byte !== want.frame_byte) begin
            $error("frame_byte: expected %h, got %h", want.frame_byte, out_data.frame_byte);
            err_cnt++;
          end
          if (out_data.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_data.last);
            err_cnt++;
          end
        end
      end
      // sink readiness: long hold-off once, otherwise a mode that changes now and then
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          stall_mode <= $urandom_range(0, 2);
          mode_left  <= $urandom_range(10, 60);
        end else begin
          mode_left <= mode_left - 1;
        end
        case (stall_mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= $urandom_range(0, 1);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Watchdog: ends a hung run
  int stuck_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == WATCHDOG_LIMIT) begin
      $display("distance_frame_formatter test failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------

  // Writes all three registers; only called with the block idle.
  task automatic program_regs(input logic en, input logic [7:0] dev, input logic [7:0] lim);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_TRANSMIT_ENABLE;
    cfg_data  <= {7'd0, en};
    @(posedge clk);
    cfg_index <= REG_DEVICE_NUMBER;
    cfg_data  <= dev;
    @(posedge clk);
    cfg_index <= REG_ABORT_LIMIT;
    cfg_data  <= lim;
    @(posedge clk);
    cfg_we    <= 1'b0;
    tx_en     = en;
    dev_num   = dev[6:0];
    abort_lim = lim;
    @(negedge clk);  // queue fills happen off the clock edge
  endtask

  // Waits until every tick is taken and every predicted result has come out,
  // then lets a trailing busy tick finish.
  task automatic wait_link_quiet();
    do @(negedge clk); while (tick_q.size() != 0 || in_valid || link_out_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly a run of busy ticks closed by a ready tick; some single noise ticks.
  task automatic queue_random_ticks(input int n, input int max_run);
    int cnt;
    int run;
    cnt = 0;
    while (cnt < n) begin
      if ($urandom_range(0, 9) < 7) begin
        run = $urandom_range(0, max_run);
        repeat (run) tick_q.push_back(make_tick(1'b1, 16'($urandom)));
        tick_q.push_back(make_tick(1'b0, pick_distance()));
        cnt += run + 1;
      end else begin
        tick_q.push_back(make_tick(1'($urandom), 16'($urandom)));
        cnt++;
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // out of reset the block is disabled: these produce nothing
    tick_q.push_back(make_tick(1'b1, 16'hFFFF));
    tick_q.push_back(make_tick(1'b0, 16'd0));
    tick_q.push_back(make_tick(1'b0, 16'd65535));
    wait_link_quiet();

    // distance extremes, digit-count edges, abort after three busy ticks,
    // ready tick clearing a partial busy count
    program_regs(1'b1, 8'd0, 8'd3);
    tick_q.push_back(make_tick(1'b0, 16'd0));
    tick_q.push_back(make_tick(1'b0, 16'd65535));
    tick_q.push_back(make_tick(1'b0, 16'd9));
    tick_q.push_back(make_tick(1'b0, 16'd10));
    tick_q.push_back(make_tick(1'b0, 16'd12345));
    repeat (3) tick_q.push_back(make_tick(1'b1, 16'd0));
    tick_q.push_back(make_tick(1'b1, 16'hFFFF));
    tick_q.push_back(make_tick(1'b0, 16'd100));
    wait_link_quiet();

    // device number past 99, then the limit dropped under the running count
    program_regs(1'b1, 8'd127, 8'd5);
    repeat (2) tick_q.push_back(make_tick(1'b1, 16'd7));
    wait_link_quiet();
    program_regs(1'b1, 8'd127, 8'd1);
    repeat (2) tick_q.push_back(make_tick(1'b1, 16'd7));
    tick_q.push_back(make_tick(1'b0, 16'd1));
    wait_link_quiet();

    // zero limit: every busy tick aborts
    program_regs(1'b1, 8'd99, 8'd0);
    repeat (2) tick_q.push_back(make_tick(1'b1, 16'd3));
    tick_q.push_back(make_tick(1'b0, 16'd99));
    wait_link_quiet();

    // disabled ticks keep the busy count
    program_regs(1'b1, 8'd42, 8'd2);
    tick_q.push_back(make_tick(1'b1, 16'd0));
    wait_link_quiet();
    program_regs(1'b0, 8'd42, 8'd2);
    tick_q.push_back(make_tick(1'b1, 16'd0));
    tick_q.push_back(make_tick(1'b0, 16'd5));
    wait_link_quiet();
    program_regs(1'b1, 8'd42, 8'd2);
    tick_q.push_back(make_tick(1'b1, 16'd0));   // count was 1, reaches 2: abort
    wait_link_quiet();

    // random traffic over several register settings
    program_regs(1'b1, 8'($urandom_range(0, 127)), 8'($urandom_range(1, 4)));
    queue_random_ticks(50, 5);
    wait_link_quiet();
    program_regs(1'b1, 8'd99, 8'd255);
    queue_random_ticks(45, 6);
    wait_link_quiet();
    program_regs(1'b1, 8'($urandom_range(0, 127)), 8'd2);
    queue_random_ticks(45, 3);
    wait_link_quiet();
    program_regs(1'b1, 8'd0, 8'd1);
    queue_random_ticks(45, 2);
    wait_link_quiet();

    if (link_out_q.size() != 0) begin
      $error("%0d predicted results never came out", link_out_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("distance_frame_formatter test passed");
    end else begin
      $display("distance_frame_formatter test failed");
    end
    $finish;
  end

endmodule
